>>> hdl/msc_pkg.sv
// package for the merge sort block: sizes, state encoding
// no dependencies
`default_nettype none
package msc_pkg;
    localparam int MaxItems  = 64;
    localparam int ValueW    = 32;
    localparam int CountW    = 9;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_MERGE,
        ST_COPY,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

>>> hdl/merge_sort_comparison_count.sv
// Iterative merge sort with comparison count. Items are loaded one per cycle
// into an internal store; a beat with tlast starts the sort. The sort is done
// by a small sequencer around one shared comparator and two memories: the store,
// read at two addresses per merge step, and the scratch, read at one. Each merge
// step and each copy-back is a registered read followed by a write. Results then
// stream out as a registered read followed by presenting the beat; the next read
// waits until that beat is taken. No input is accepted while sorting or emitting.
// The merge order matches a top-down sort splitting each range at floor of its
// midpoint, walked over an explicit range stack.
// depends on msc_pkg
`default_nettype none
module merge_sort_comparison_count #(
    parameter int MAX_ITEMS = msc_pkg::MaxItems
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value[31:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // sorted_value[31:0], comparisons[40:32], dropped[41]
    output logic             m_axis_tlast
);
    localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = AW + 1;
    localparam int SD  = 2 * AW + 1;
    localparam int SPW = $clog2(SD + 1);

    logic [31:0] r_store [MAX_ITEMS];
    logic [31:0] r_scr   [MAX_ITEMS];

    msc_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [8:0]    r_cmp;
    // explicit recursion stack: lo, hi, phase (0 = not yet split, 1 = halves done)
    logic [AW-1:0] r_slo [SD];
    logic [AW-1:0] r_shi [SD];
    logic          r_sph [SD];
    logic [SPW-1:0] r_sp;
    logic [AW-1:0] r_lo, r_mid, r_hi, r_a, r_b, r_k;
    logic          r_a_ok, r_b_ok;
    logic          r_rd;   // read data valid phase
    logic [31:0]   r_va, r_vb;
    logic [CW-1:0] r_oi;

    logic [AW-1:0] top_lo, top_hi, mid_c;
    assign top_lo = r_slo[r_sp-1];
    assign top_hi = r_shi[r_sp-1];
    assign mid_c  = AW'(({1'b0, top_lo} + {1'b0, top_hi}) >> 1);

    assign s_axis_tready = (r_state == msc_pkg::ST_LOAD);
    wire in_acc = s_axis_tvalid && s_axis_tready;
    wire take_a = r_a_ok && (!r_b_ok || ($signed(r_va) <= $signed(r_vb)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            msc_pkg::ST_LOAD: if (in_acc && s_axis_tlast) n_state = msc_pkg::ST_PASS;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msc_pkg::ST_LOAD;
            r_cnt <= '0; r_ovf <= 1'b0; r_cmp <= '0; r_sp <= '0; r_rd <= 1'b0;
            r_oi <= '0;
        end else begin
            case (r_state)
                msc_pkg::ST_LOAD: if (in_acc) begin
                    logic [CW-1:0] nc;
                    nc = r_cnt;
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        r_store[r_cnt[AW-1:0]] <= s_axis_tdata;
                        nc = r_cnt + 1'b1;
                    end else r_ovf <= 1'b1;
                    r_cnt <= nc;
                    if (s_axis_tlast) begin
                        r_cmp <= '0; r_oi <= '0;
                        if (nc == '0) r_state <= msc_pkg::ST_LOAD;
                        else begin
                            r_slo[0] <= '0; r_shi[0] <= AW'(nc - 1'b1); r_sph[0] <= 1'b0;
                            r_sp <= SPW'(1); r_state <= msc_pkg::ST_PASS;
                        end
                    end
                end
                msc_pkg::ST_PASS: begin
                    if (r_sp == 0) r_state <= msc_pkg::ST_OUT;
                    else if (top_lo >= top_hi) r_sp <= r_sp - 1'b1;
                    else if (!r_sph[r_sp-1]) begin
                        r_sph[r_sp-1] <= 1'b1;
                        r_slo[r_sp] <= mid_c + 1'b1; r_shi[r_sp] <= top_hi; r_sph[r_sp] <= 1'b0;
                        r_slo[r_sp+1] <= top_lo; r_shi[r_sp+1] <= mid_c; r_sph[r_sp+1] <= 1'b0;
                        r_sp <= r_sp + 2'd2;
                    end else begin
                        r_lo <= top_lo; r_hi <= top_hi; r_mid <= mid_c;
                        r_a <= top_lo; r_b <= mid_c + 1'b1; r_k <= top_lo;
                        r_a_ok <= 1'b1; r_b_ok <= 1'b1; r_rd <= 1'b0;
                        r_sp <= r_sp - 1'b1;
                        r_state <= msc_pkg::ST_MERGE;
                    end
                end
                msc_pkg::ST_MERGE: begin
                    if (!r_rd) begin
                        r_va <= r_store[r_a]; r_vb <= r_store[r_b]; r_rd <= 1'b1;
                    end else begin
                        r_rd <= 1'b0;
                        if (r_a_ok && r_b_ok) r_cmp <= r_cmp + 1'b1;
                        if (take_a) begin
                            r_scr[r_k] <= r_va;
                            if (r_a == r_mid) r_a_ok <= 1'b0; else r_a <= r_a + 1'b1;
                        end else begin
                            r_scr[r_k] <= r_vb;
                            if (r_b == r_hi) r_b_ok <= 1'b0; else r_b <= r_b + 1'b1;
                        end
                        if (r_k == r_hi) begin
                            r_k <= r_lo; r_state <= msc_pkg::ST_COPY;
                        end else r_k <= r_k + 1'b1;
                    end
                end
                msc_pkg::ST_COPY: begin
                    if (!r_rd) begin
                        r_va <= r_scr[r_k]; r_rd <= 1'b1;
                    end else begin
                        r_rd <= 1'b0;
                        r_store[r_k] <= r_va;
                        if (r_k == r_hi) r_state <= msc_pkg::ST_PASS;
                        else r_k <= r_k + 1'b1;
                    end
                end
                msc_pkg::ST_OUT: begin
                    if (!r_rd) begin
                        r_va <= r_store[r_oi[AW-1:0]]; r_rd <= 1'b1;
                    end else if (m_axis_tready) begin
                        r_rd <= 1'b0;
                        if (r_oi + 1'b1 == r_cnt) begin
                            r_state <= msc_pkg::ST_LOAD;
                            r_cnt <= '0; r_ovf <= 1'b0; r_cmp <= '0;
                        end
                        r_oi <= r_oi + 1'b1;
                    end
                end
                default: r_state <= n_state;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == msc_pkg::ST_OUT) && r_rd;
    assign m_axis_tdata  = {6'd0, r_ovf, r_cmp, r_va};
    assign m_axis_tlast  = (r_oi + 1'b1 == r_cnt);
endmodule
`default_nettype wire

>>> sim/testbench.sv
// testbench for merge_sort_comparison_count: streams sets of signed values,
// predicts sorted output and comparison counts, checks every output beat
// depends on msc_pkg and merge_sort_comparison_count
`default_nettype none
module testbench;
    localparam int Cap      = msc_pkg::MaxItems;
    localparam int CycLimit = 2000000;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic [31:0]     value;
        logic [msc_pkg::CountW-1:0] cmps;
        logic            eos;
        logic            dropped;
    } t_sorted_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    merge_sort_comparison_count dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    t_in_beat     pending_q[$];
    t_sorted_beat sorted_q[$];

    logic signed [31:0] set_vals[Cap];
    logic signed [31:0] scratch[Cap];
    int          set_count;
    logic [msc_pkg::CountW-1:0] cmp_total;
    logic        ovf_seen;

    int  errors = 0;
    int  cycles = 0;
    int  sets_done = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    logic s_axis_tready_q = 1'b0;

    task automatic merge_halves(input int lo, input int mid, input int hi);
        int a, b, k;
        a = lo; b = mid + 1; k = lo;
        while (a <= mid && b <= hi) begin
            if (set_vals[a] <= set_vals[b]) begin
                scratch[k] = set_vals[a]; a++;
            end else begin
                scratch[k] = set_vals[b]; b++;
            end
            k++;
            cmp_total = cmp_total + 1'b1;
        end
        while (a <= mid) begin scratch[k] = set_vals[a]; k++; a++; end
        while (b <= hi) begin scratch[k] = set_vals[b]; k++; b++; end
        for (int i = lo; i <= hi; i++) set_vals[i] = scratch[i];
    endtask

    task automatic sort_span(input int lo, input int hi);
        int mid;
        if (lo >= hi) return;
        mid = (lo + hi) / 2;
        sort_span(lo, mid);
        sort_span(mid + 1, hi);
        merge_halves(lo, mid, hi);
    endtask

    task automatic predict_sorted(input t_in_beat b);
        t_sorted_beat r;
        if (set_count < Cap) begin
            set_vals[set_count] = b.value;
            set_count++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!b.last) return;
        cmp_total = '0;
        if (set_count > 0) sort_span(0, set_count - 1);
        for (int i = 0; i < set_count; i++) begin
            r.value = set_vals[i];
            r.cmps = cmp_total;
            r.eos = (i + 1 == set_count);
            r.dropped = ovf_seen;
            sorted_q.push_back(r);
        end
        set_count = 0;
        cmp_total = '0;
        ovf_seen = 1'b0;
        sets_done++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 7);
            3: return -$urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_set(input int n);
        t_in_beat b;
        for (int i = 0; i < n; i++) begin
            b.value = rand_value();
            b.last = (i == n - 1);
            pending_q.push_back(b);
        end
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready_q) begin
                predict_sorted(pending_q.pop_front());
                beats_in++;
            end
            if ((!s_axis_tvalid || s_axis_tready_q) ) begin
                if (pending_q.size() > 0 &&
                    $urandom_range(0, 99) >= idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_q[0].value;
                    s_axis_tlast  <= pending_q[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_sorted_beat got, exp_b;
        s_axis_tready_q <= s_axis_tready;
        cycles++;
        if (cycles > CycLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL merge_sort_comparison_count");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.value = m_axis_tdata[31:0];
            got.cmps = m_axis_tdata[40:32];
            got.dropped = m_axis_tdata[41];
            got.eos = m_axis_tlast;
            beats_out++;
            if (sorted_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat %h", m_axis_tdata);
            end else begin
                exp_b = sorted_q.pop_front();
                if (got !== exp_b) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch beat %0d: exp val %0d cmp %0d last %b drop %b",
                            beats_out, $signed(exp_b.value), exp_b.cmps, exp_b.eos,
                            exp_b.dropped);
                        $display("    got val %0d cmp %0d last %b drop %b",
                            $signed(got.value), got.cmps, got.eos, got.dropped);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (sorted_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        t_in_beat b;
        set_count = 0;
        cmp_total = '0;
        ovf_seen = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single item, extremes, ties, reversed run
        b.value = 32'h8000_0000; b.last = 1'b1; pending_q.push_back(b);
        b.value = 32'h7fff_ffff; b.last = 1'b0; pending_q.push_back(b);
        b.value = 32'h8000_0000; b.last = 1'b0; pending_q.push_back(b);
        b.value = 32'h0000_0000; b.last = 1'b0; pending_q.push_back(b);
        b.value = 32'hffff_ffff; b.last = 1'b1; pending_q.push_back(b);
        for (int i = 0; i < 6; i++) begin
            b.value = 32'd5; b.last = (i == 5); pending_q.push_back(b);
        end
        for (int i = 0; i < 8; i++) begin
            b.value = 8 - i; b.last = (i == 7); pending_q.push_back(b);
        end
        wait_drained();

        // full store, then overflow with last on a dropped item
        add_set(Cap);
        wait_drained();
        for (int i = 0; i < Cap + 3; i++) begin
            b.value = $urandom; b.last = (i == Cap + 2); pending_q.push_back(b);
        end
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 28 : 0;
            stall_pct = (ph == 2) ? 50 : (ph == 3) ? 28 : 0;
            for (int s = 0; s < 8; s++) begin
                if (s == 0 && ph % 2 == 1) add_set($urandom_range(Cap - 2, Cap + 2));
                else add_set($urandom_range(1, 8));
            end
            // sender stays quiet until every expected beat has come back
            wait_drained();
        end
        idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("sent %0d beats in %0d sets, checked %0d sorted beats",
            beats_in, sets_done, beats_out);
        if (errors == 0 && sorted_q.size() == 0) begin
            $display("PASS merge_sort_comparison_count");
        end else begin
            $display("%0d mismatches, %0d beats left", errors, sorted_q.size());
            $display("FAIL merge_sort_comparison_count");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
hdl/msc_pkg.sv
hdl/merge_sort_comparison_count.sv
sim/testbench.sv
